### rtl/tic_pkg.sv
// shared types, constants and step program for the inscribed cone test
package tic_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int WORD_W = 256;
  localparam int MAG_W = 128;
  localparam int SQ_IN_W = 136;
  localparam int SQ_OUT_W = 68;
  localparam int SQ_REM_W = 72;
  localparam int ADDR_W = 6;
  localparam int PC_W = 7;
  localparam logic [15:0] SINE_RESET = 16'd11943;

  typedef struct packed {
    logic [2:0] vertex_slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } item_t;

  typedef struct packed {
    logic removable;
    logic degenerate;
  } result_t;

  typedef enum logic [1:0] {OP_MUL, OP_MAC, OP_MSC, OP_SQRT} op_kind_t;

  typedef struct packed {
    logic go;
    op_kind_t kind;
  } mul_ctl_t;

  typedef struct packed {
    op_kind_t kind;
    logic store;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } uop_t;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_FETCH, S_GO, S_WAIT} state_t;

  localparam logic [ADDR_W-1:0] R_B = 6'd0;
  localparam logic [ADDR_W-1:0] R_C = 6'd3;
  localparam logic [ADDR_W-1:0] R_D = 6'd6;
  localparam logic [ADDR_W-1:0] R_A = 6'd9;
  localparam logic [ADDR_W-1:0] R_AB = 6'd12;
  localparam logic [ADDR_W-1:0] R_AC = 6'd15;
  localparam logic [ADDR_W-1:0] R_AD = 6'd18;
  localparam logic [ADDR_W-1:0] R_CB = 6'd21;
  localparam logic [ADDR_W-1:0] R_DB = 6'd24;
  localparam logic [ADDR_W-1:0] R_N = 6'd27;
  localparam logic [ADDR_W-1:0] R_T = 6'd30;
  localparam logic [ADDR_W-1:0] R_DET = 6'd31;
  localparam logic [ADDR_W-1:0] R_MA = 6'd32;
  localparam logic [ADDR_W-1:0] R_MB = 6'd33;
  localparam logic [ADDR_W-1:0] R_MC = 6'd34;
  localparam logic [ADDR_W-1:0] R_MD = 6'd35;
  localparam logic [ADDR_W-1:0] R_S = 6'd36;
  localparam logic [ADDR_W-1:0] R_W = 6'd37;
  localparam logic [ADDR_W-1:0] R_WW = 6'd40;
  localparam logic [ADDR_W-1:0] R_DD = 6'd41;
  localparam logic [ADDR_W-1:0] R_SG2 = 6'd42;
  localparam logic [ADDR_W-1:0] K_ONE = 6'd61;
  localparam logic [ADDR_W-1:0] K_TWO32 = 6'd62;
  localparam logic [ADDR_W-1:0] K_SIG = 6'd63;

  localparam logic [PC_W-1:0] LAST_PC = 7'd92;

  function automatic uop_t mk(input op_kind_t k, input logic st, input logic [ADDR_W-1:0] d,
                              input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b);
    uop_t u;
    u.kind = k;
    u.store = st;
    u.dst = d;
    u.a = a;
    u.b = b;
    return u;
  endfunction

  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // edge vectors
      7'd0: u = mk(OP_MUL, 1'b0, R_AB, R_B, K_ONE);
      7'd1: u = mk(OP_MSC, 1'b1, R_AB, R_A, K_ONE);
      7'd2: u = mk(OP_MUL, 1'b0, R_AB, R_B + 6'd1, K_ONE);
      7'd3: u = mk(OP_MSC, 1'b1, R_AB + 6'd1, R_A + 6'd1, K_ONE);
      7'd4: u = mk(OP_MUL, 1'b0, R_AB, R_B + 6'd2, K_ONE);
      7'd5: u = mk(OP_MSC, 1'b1, R_AB + 6'd2, R_A + 6'd2, K_ONE);
      7'd6: u = mk(OP_MUL, 1'b0, R_AC, R_C, K_ONE);
      7'd7: u = mk(OP_MSC, 1'b1, R_AC, R_A, K_ONE);
      7'd8: u = mk(OP_MUL, 1'b0, R_AC, R_C + 6'd1, K_ONE);
      7'd9: u = mk(OP_MSC, 1'b1, R_AC + 6'd1, R_A + 6'd1, K_ONE);
      7'd10: u = mk(OP_MUL, 1'b0, R_AC, R_C + 6'd2, K_ONE);
      7'd11: u = mk(OP_MSC, 1'b1, R_AC + 6'd2, R_A + 6'd2, K_ONE);
      7'd12: u = mk(OP_MUL, 1'b0, R_AD, R_D, K_ONE);
      7'd13: u = mk(OP_MSC, 1'b1, R_AD, R_A, K_ONE);
      7'd14: u = mk(OP_MUL, 1'b0, R_AD, R_D + 6'd1, K_ONE);
      7'd15: u = mk(OP_MSC, 1'b1, R_AD + 6'd1, R_A + 6'd1, K_ONE);
      7'd16: u = mk(OP_MUL, 1'b0, R_AD, R_D + 6'd2, K_ONE);
      7'd17: u = mk(OP_MSC, 1'b1, R_AD + 6'd2, R_A + 6'd2, K_ONE);
      7'd18: u = mk(OP_MUL, 1'b0, R_CB, R_C, K_ONE);
      7'd19: u = mk(OP_MSC, 1'b1, R_CB, R_B, K_ONE);
      7'd20: u = mk(OP_MUL, 1'b0, R_CB, R_C + 6'd1, K_ONE);
      7'd21: u = mk(OP_MSC, 1'b1, R_CB + 6'd1, R_B + 6'd1, K_ONE);
      7'd22: u = mk(OP_MUL, 1'b0, R_CB, R_C + 6'd2, K_ONE);
      7'd23: u = mk(OP_MSC, 1'b1, R_CB + 6'd2, R_B + 6'd2, K_ONE);
      7'd24: u = mk(OP_MUL, 1'b0, R_DB, R_D, K_ONE);
      7'd25: u = mk(OP_MSC, 1'b1, R_DB, R_B, K_ONE);
      7'd26: u = mk(OP_MUL, 1'b0, R_DB, R_D + 6'd1, K_ONE);
      7'd27: u = mk(OP_MSC, 1'b1, R_DB + 6'd1, R_B + 6'd1, K_ONE);
      7'd28: u = mk(OP_MUL, 1'b0, R_DB, R_D + 6'd2, K_ONE);
      7'd29: u = mk(OP_MSC, 1'b1, R_DB + 6'd2, R_B + 6'd2, K_ONE);
      // face bcd
      7'd30: u = mk(OP_MUL, 1'b0, R_N, R_CB + 6'd1, R_DB + 6'd2);
      7'd31: u = mk(OP_MSC, 1'b1, R_N, R_CB + 6'd2, R_DB + 6'd1);
      7'd32: u = mk(OP_MUL, 1'b0, R_N, R_CB + 6'd2, R_DB);
      7'd33: u = mk(OP_MSC, 1'b1, R_N + 6'd1, R_CB, R_DB + 6'd2);
      7'd34: u = mk(OP_MUL, 1'b0, R_N, R_CB, R_DB + 6'd1);
      7'd35: u = mk(OP_MSC, 1'b1, R_N + 6'd2, R_CB + 6'd1, R_DB);
      7'd36: u = mk(OP_MUL, 1'b0, R_T, R_N, R_N);
      7'd37: u = mk(OP_MAC, 1'b0, R_T, R_N + 6'd1, R_N + 6'd1);
      7'd38: u = mk(OP_MAC, 1'b1, R_T, R_N + 6'd2, R_N + 6'd2);
      7'd39: u = mk(OP_SQRT, 1'b1, R_MA, R_T, R_T);
      // face acd, its normal also gives the volume
      7'd40: u = mk(OP_MUL, 1'b0, R_N, R_AC + 6'd1, R_AD + 6'd2);
      7'd41: u = mk(OP_MSC, 1'b1, R_N, R_AC + 6'd2, R_AD + 6'd1);
      7'd42: u = mk(OP_MUL, 1'b0, R_N, R_AC + 6'd2, R_AD);
      7'd43: u = mk(OP_MSC, 1'b1, R_N + 6'd1, R_AC, R_AD + 6'd2);
      7'd44: u = mk(OP_MUL, 1'b0, R_N, R_AC, R_AD + 6'd1);
      7'd45: u = mk(OP_MSC, 1'b1, R_N + 6'd2, R_AC + 6'd1, R_AD);
      7'd46: u = mk(OP_MUL, 1'b0, R_DET, R_N, R_AB);
      7'd47: u = mk(OP_MAC, 1'b0, R_DET, R_N + 6'd1, R_AB + 6'd1);
      7'd48: u = mk(OP_MAC, 1'b1, R_DET, R_N + 6'd2, R_AB + 6'd2);
      7'd49: u = mk(OP_MUL, 1'b0, R_T, R_N, R_N);
      7'd50: u = mk(OP_MAC, 1'b0, R_T, R_N + 6'd1, R_N + 6'd1);
      7'd51: u = mk(OP_MAC, 1'b1, R_T, R_N + 6'd2, R_N + 6'd2);
      7'd52: u = mk(OP_SQRT, 1'b1, R_MB, R_T, R_T);
      // face adb
      7'd53: u = mk(OP_MUL, 1'b0, R_N, R_AD + 6'd1, R_AB + 6'd2);
      7'd54: u = mk(OP_MSC, 1'b1, R_N, R_AD + 6'd2, R_AB + 6'd1);
      7'd55: u = mk(OP_MUL, 1'b0, R_N, R_AD + 6'd2, R_AB);
      7'd56: u = mk(OP_MSC, 1'b1, R_N + 6'd1, R_AD, R_AB + 6'd2);
      7'd57: u = mk(OP_MUL, 1'b0, R_N, R_AD, R_AB + 6'd1);
      7'd58: u = mk(OP_MSC, 1'b1, R_N + 6'd2, R_AD + 6'd1, R_AB);
      7'd59: u = mk(OP_MUL, 1'b0, R_T, R_N, R_N);
      7'd60: u = mk(OP_MAC, 1'b0, R_T, R_N + 6'd1, R_N + 6'd1);
      7'd61: u = mk(OP_MAC, 1'b1, R_T, R_N + 6'd2, R_N + 6'd2);
      7'd62: u = mk(OP_SQRT, 1'b1, R_MC, R_T, R_T);
      // face abc
      7'd63: u = mk(OP_MUL, 1'b0, R_N, R_AB + 6'd1, R_AC + 6'd2);
      7'd64: u = mk(OP_MSC, 1'b1, R_N, R_AB + 6'd2, R_AC + 6'd1);
      7'd65: u = mk(OP_MUL, 1'b0, R_N, R_AB + 6'd2, R_AC);
      7'd66: u = mk(OP_MSC, 1'b1, R_N + 6'd1, R_AB, R_AC + 6'd2);
      7'd67: u = mk(OP_MUL, 1'b0, R_N, R_AB, R_AC + 6'd1);
      7'd68: u = mk(OP_MSC, 1'b1, R_N + 6'd2, R_AB + 6'd1, R_AC);
      7'd69: u = mk(OP_MUL, 1'b0, R_T, R_N, R_N);
      7'd70: u = mk(OP_MAC, 1'b0, R_T, R_N + 6'd1, R_N + 6'd1);
      7'd71: u = mk(OP_MAC, 1'b1, R_T, R_N + 6'd2, R_N + 6'd2);
      7'd72: u = mk(OP_SQRT, 1'b1, R_MD, R_T, R_T);
      // area sum
      7'd73: u = mk(OP_MUL, 1'b0, R_S, R_MA, K_ONE);
      7'd74: u = mk(OP_MAC, 1'b0, R_S, R_MB, K_ONE);
      7'd75: u = mk(OP_MAC, 1'b0, R_S, R_MC, K_ONE);
      7'd76: u = mk(OP_MAC, 1'b1, R_S, R_MD, K_ONE);
      // weighted apex offset
      7'd77: u = mk(OP_MUL, 1'b0, R_W, R_MB, R_AB);
      7'd78: u = mk(OP_MAC, 1'b0, R_W, R_MC, R_AC);
      7'd79: u = mk(OP_MAC, 1'b1, R_W, R_MD, R_AD);
      7'd80: u = mk(OP_MUL, 1'b0, R_W, R_MB, R_AB + 6'd1);
      7'd81: u = mk(OP_MAC, 1'b0, R_W, R_MC, R_AC + 6'd1);
      7'd82: u = mk(OP_MAC, 1'b1, R_W + 6'd1, R_MD, R_AD + 6'd1);
      7'd83: u = mk(OP_MUL, 1'b0, R_W, R_MB, R_AB + 6'd2);
      7'd84: u = mk(OP_MAC, 1'b0, R_W, R_MC, R_AC + 6'd2);
      7'd85: u = mk(OP_MAC, 1'b1, R_W + 6'd2, R_MD, R_AD + 6'd2);
      7'd86: u = mk(OP_MUL, 1'b0, R_WW, R_W, R_W);
      7'd87: u = mk(OP_MAC, 1'b0, R_WW, R_W + 6'd1, R_W + 6'd1);
      7'd88: u = mk(OP_MAC, 1'b1, R_WW, R_W + 6'd2, R_W + 6'd2);
      // final compare
      7'd89: u = mk(OP_MUL, 1'b1, R_DD, R_DET, R_DET);
      7'd90: u = mk(OP_MUL, 1'b1, R_SG2, K_SIG, K_SIG);
      7'd91: u = mk(OP_MUL, 1'b0, R_T, R_DD, K_TWO32);
      7'd92: u = mk(OP_MSC, 1'b0, R_T, R_WW, R_SG2);
      default: u = mk(OP_MUL, 1'b0, R_T, K_ONE, K_ONE);
    endcase
    return u;
  endfunction

endpackage

### rtl/tic_mul.sv
// iterative shift-add signed multiply-accumulate unit
module tic_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  tic_pkg::mul_ctl_t             ctl,
  input  logic [tic_pkg::WORD_W-1:0]    a,
  input  logic [tic_pkg::WORD_W-1:0]    b,
  output logic [tic_pkg::WORD_W-1:0]    acc,
  output logic                          done
);
  import tic_pkg::*;

  logic              active;
  logic [WORD_W-1:0] a_sh;
  logic [MAG_W-1:0]  b_mag;
  logic              sub;
  logic [WORD_W-1:0] b_abs;

  assign b_abs = b[WORD_W-1] ? (~b + {{(WORD_W-1){1'b0}}, 1'b1}) : b;
  assign done = active && (b_mag == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctl.go) begin
      active <= 1'b1;
    end else if (done) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      a_sh <= a;
      b_mag <= b_abs[MAG_W-1:0];
      sub <= (ctl.kind == OP_MSC) ^ b[WORD_W-1];
      if (ctl.kind == OP_MUL) begin
        acc <= '0;
      end
    end else if (active && (b_mag != '0)) begin
      if (b_mag[0]) begin
        acc <= sub ? (acc - a_sh) : (acc + a_sh);
      end
      a_sh <= {a_sh[WORD_W-2:0], 1'b0};
      b_mag <= {1'b0, b_mag[MAG_W-1:1]};
    end
  end

endmodule

### rtl/tic_sqrt.sv
// iterative floor square root, two radicand bits per cycle
module tic_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [tic_pkg::SQ_IN_W-1:0]   x,
  output logic [tic_pkg::SQ_OUT_W-1:0]  root,
  output logic                          done
);
  import tic_pkg::*;

  localparam int CNT_W = $clog2(SQ_OUT_W + 1);

  logic                active;
  logic [CNT_W-1:0]    cnt;
  logic [SQ_IN_W-1:0]  xs;
  logic [SQ_REM_W-1:0] rem;
  logic [SQ_REM_W-1:0] rem_sh;
  logic [SQ_REM_W-1:0] trial;

  assign rem_sh = {rem[SQ_REM_W-3:0], xs[SQ_IN_W-1:SQ_IN_W-2]};
  assign trial = {{(SQ_REM_W-SQ_OUT_W-2){1'b0}}, root, 2'b01};
  assign done = active && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (go) begin
      active <= 1'b1;
    end else if (done) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      xs <= x;
      rem <= '0;
      root <= '0;
      cnt <= CNT_W'(SQ_OUT_W);
    end else if (active && (cnt != '0)) begin
      if (rem_sh >= trial) begin
        rem <= rem_sh - trial;
        root <= {root[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        root <= {root[SQ_OUT_W-2:0], 1'b0};
      end
      xs <= {xs[SQ_IN_W-3:0], 2'b00};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

### rtl/tetra_inscribed_cone_test_core.sv
// inscribed cone test on one tetrahedron: sequencer, value store and shared units
//
// Vertices come in one beat each on start/busy; the result beat is strobed on
// done for one cycle and cannot be stalled. A base or winning apex vertex
// is stored with 3 store writes, a losing apex vertex is not stored. Slot 5 then
// runs a fixed program of 93 steps on one shift-add multiply-accumulate unit
// and one square root unit: each multiply step takes longer the more bits the
// second operand's magnitude has, and 4 of the steps are square roots, so a
// test finishes sooner for short coordinates.
// The limit register sits at byte address 0.
module tetra_inscribed_cone_test_core #(
  parameter int COORD_WIDTH = tic_pkg::COORD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tic_pkg::item_t   item,
  output logic             done,
  output tic_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tic_pkg::*;

  localparam int EFF_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  state_t                   state, state_next;
  logic [PC_W-1:0]          pc, pc_next;
  logic [1:0]               cnt, cnt_next;
  logic                     run;
  logic [ADDR_W-1:0]        wr_base;
  logic signed [31:0]       cx, cy, cz;
  logic signed [31:0]       apex_y;
  logic [15:0]              sine;
  logic                     szero, wnz;
  logic [WORD_W-1:0]        mem [2**ADDR_W];
  logic [WORD_W-1:0]        rd_a, rd_b;
  logic [WORD_W-1:0]        mul_acc;
  logic                     mul_done;
  logic [SQ_OUT_W-1:0]      sq_root;
  logic                     sq_done;
  mul_ctl_t                 mul_ctl;
  logic                     sq_go;
  uop_t                     uop;
  logic                     in_take;
  logic signed [31:0]       in_x, in_y, in_z;
  logic                     take_apex, in_wr, in_run;
  logic                     unit_done;
  logic signed [31:0]       ld_val;

  assign busy = (state != S_IDLE);
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, sine};

  assign uop = prog(pc);
  assign in_take = start && (state == S_IDLE);
  assign in_x = 32'($signed(item.coord_x[EFF_W-1:0]));
  assign in_y = 32'($signed(item.coord_y[EFF_W-1:0]));
  assign in_z = 32'($signed(item.coord_z[EFF_W-1:0]));
  assign take_apex = (item.vertex_slot == 3'd3)
                  || (((item.vertex_slot == 3'd4) || (item.vertex_slot == 3'd5))
                      && (in_y > apex_y));
  assign in_wr = (item.vertex_slot <= 3'd2) || take_apex;
  assign in_run = (item.vertex_slot == 3'd5);
  assign unit_done = (uop.kind == OP_SQRT) ? sq_done : mul_done;
  assign ld_val = (cnt == 2'd0) ? cx : ((cnt == 2'd1) ? cy : cz);

  assign mul_ctl.go = (state == S_GO) && (uop.kind != OP_SQRT);
  assign mul_ctl.kind = uop.kind;
  assign sq_go = (state == S_GO) && (uop.kind == OP_SQRT);

  tic_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a    (rd_a),
    .b    (rd_b),
    .acc  (mul_acc),
    .done (mul_done)
  );

  tic_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .go   (sq_go),
    .x    (rd_a[SQ_IN_W-1:0]),
    .root (sq_root),
    .done (sq_done)
  );

  always_comb begin
    state_next = state;
    pc_next = pc;
    cnt_next = cnt;
    case (state)
      S_IDLE: begin
        pc_next = '0;
        cnt_next = 2'd0;
        if (in_take) begin
          if (in_wr) begin
            state_next = S_LOAD;
          end else if (in_run) begin
            state_next = S_FETCH;
          end
        end
      end
      S_LOAD: begin
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd2) begin
          state_next = run ? S_FETCH : S_IDLE;
        end
      end
      S_FETCH: state_next = S_GO;
      S_GO: state_next = S_WAIT;
      S_WAIT: begin
        if (unit_done) begin
          if (pc == LAST_PC) begin
            state_next = S_IDLE;
          end else begin
            pc_next = pc + 1'b1;
            state_next = S_FETCH;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      cnt <= 2'd0;
      run <= 1'b0;
      szero <= 1'b0;
      wnz <= 1'b0;
      done <= 1'b0;
      sine <= SINE_RESET;
    end else begin
      state <= state_next;
      pc <= pc_next;
      cnt <= cnt_next;
      done <= (state == S_WAIT) && unit_done && (pc == LAST_PC);
      if (in_take) begin
        run <= in_run;
        szero <= 1'b0;
        wnz <= 1'b0;
      end
      if ((state == S_WAIT) && unit_done && uop.store) begin
        if (uop.dst == R_S) begin
          szero <= (mul_acc == '0);
        end
        if ((uop.dst == R_W) || (uop.dst == R_W + 6'd1) || (uop.dst == R_W + 6'd2)) begin
          wnz <= wnz || (mul_acc != '0);
        end
      end
      if (psel && penable && pwrite && !paddr[2]) begin
        sine <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cx <= in_x;
      cy <= in_y;
      cz <= in_z;
      wr_base <= (item.vertex_slot <= 3'd2)
               ? ({2'b00, item.vertex_slot, 1'b0} + {3'b000, item.vertex_slot})
               : R_A;
      if (take_apex) begin
        apex_y <= in_y;
      end
    end
    if ((state == S_WAIT) && unit_done && (pc == LAST_PC)) begin
      result.degenerate <= szero;
      result.removable <= !szero && wnz && !mul_acc[WORD_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      mem[wr_base + {4'd0, cnt}] <= WORD_W'(ld_val);
    end else if ((state == S_WAIT) && unit_done && uop.store) begin
      if (uop.kind == OP_SQRT) begin
        mem[uop.dst] <= {{(WORD_W-SQ_OUT_W){1'b0}}, sq_root};
      end else begin
        mem[uop.dst] <= mul_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      case (uop.a)
        K_ONE: rd_a <= WORD_W'(1);
        K_TWO32: rd_a <= WORD_W'(1) << 32;
        K_SIG: rd_a <= {{(WORD_W-16){1'b0}}, sine};
        default: rd_a <= mem[uop.a];
      endcase
      case (uop.b)
        K_ONE: rd_b <= WORD_W'(1);
        K_TWO32: rd_b <= WORD_W'(1) << 32;
        K_SIG: rd_b <= {{(WORD_W-16){1'b0}}, sine};
        default: rd_b <= mem[uop.b];
      endcase
    end
  end

endmodule

### bench/tb_top.sv
// testbench for the inscribed cone test core: queue-fed driver, predictor and result checker
`timescale 1ns / 1ps

module tb_top;
  import tic_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef struct packed {
    logic signed [255:0] x;
    logic signed [255:0] y;
    logic signed [255:0] z;
  } vec3_t;

  localparam logic [2:0] REG_SINE_LIMIT = 3'd0;
  localparam logic [2:0] REG_UNUSED = 3'd4;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic done;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tetra_inscribed_cone_test_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  item_t vertex_q[$];
  result_t verdict_q[$];
  logic [15:0] sine_limit = SINE_RESET;
  logic signed [31:0] base_xyz[9];
  logic signed [31:0] apex_xyz[3];
  int errors = 0;
  int tests_seen = 0;
  int removable_seen = 0;
  int degenerate_seen = 0;
  int idle_cycles = 0;
  logic beat_taken = 1'b0;
  int burst_left = 5;
  int gap_left = 0;

  function automatic vec3_t vsub(input vec3_t p, input vec3_t q);
    vec3_t o;
    o.x = p.x - q.x;
    o.y = p.y - q.y;
    o.z = p.z - q.z;
    return o;
  endfunction

  function automatic vec3_t vcross(input vec3_t u, input vec3_t v);
    vec3_t o;
    o.x = u.y * v.z - u.z * v.y;
    o.y = u.z * v.x - u.x * v.z;
    o.z = u.x * v.y - u.y * v.x;
    return o;
  endfunction

  function automatic wide_t vdot(input vec3_t u, input vec3_t v);
    return u.x * v.x + u.y * v.y + u.z * v.z;
  endfunction

  function automatic wide_t isqrt(input wide_t v);
    wide_t r;
    wide_t c;
    r = '0;
    for (int b = 67; b >= 0; b--) begin
      c = r | (wide_t'(1) << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic wide_t twice_area(input vec3_t p, input vec3_t q, input vec3_t r);
    vec3_t n;
    n = vcross(vsub(q, p), vsub(r, p));
    return isqrt(vdot(n, n));
  endfunction

  function automatic vec3_t widen(input logic signed [31:0] x, input logic signed [31:0] y,
                                  input logic signed [31:0] z);
    vec3_t o;
    o.x = x;
    o.y = y;
    o.z = z;
    return o;
  endfunction

  function automatic result_t cone_verdict();
    vec3_t a, b, c, d, ab, ac, ad, w;
    wide_t ma, mb, mc, md, det, lhs, rhs, sg;
    result_t res;
    a = widen(apex_xyz[0], apex_xyz[1], apex_xyz[2]);
    b = widen(base_xyz[0], base_xyz[1], base_xyz[2]);
    c = widen(base_xyz[3], base_xyz[4], base_xyz[5]);
    d = widen(base_xyz[6], base_xyz[7], base_xyz[8]);
    ma = twice_area(b, c, d);
    mb = twice_area(a, c, d);
    mc = twice_area(a, d, b);
    md = twice_area(a, b, c);
    res = '0;
    if (ma + mb + mc + md == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    ab = vsub(b, a);
    ac = vsub(c, a);
    ad = vsub(d, a);
    det = vdot(ab, vcross(ac, ad));
    w.x = mb * ab.x + mc * ac.x + md * ad.x;
    w.y = mb * ab.y + mc * ac.y + md * ad.y;
    w.z = mb * ab.z + mc * ac.z + md * ad.z;
    if (w.x == 0 && w.y == 0 && w.z == 0) return res;
    sg = {240'd0, sine_limit};
    lhs = det * det * (wide_t'(1) << 32);
    rhs = sg * sg * vdot(w, w);
    res.removable = (lhs >= rhs);
    return res;
  endfunction

  // predictor and checker
  always @(posedge clk) begin
    beat_taken <= start && !busy;
    if (!rst && start && !busy) begin
      if (item.vertex_slot <= 3'd2) begin
        base_xyz[4'(item.vertex_slot * 3)] = item.coord_x;
        base_xyz[4'(item.vertex_slot * 3 + 1)] = item.coord_y;
        base_xyz[4'(item.vertex_slot * 3 + 2)] = item.coord_z;
      end else if (item.vertex_slot == 3'd3 ||
                   ((item.vertex_slot == 3'd4 || item.vertex_slot == 3'd5) &&
                    item.coord_y > apex_xyz[1])) begin
        apex_xyz[0] = item.coord_x;
        apex_xyz[1] = item.coord_y;
        apex_xyz[2] = item.coord_z;
      end
      if (item.vertex_slot == 3'd5) verdict_q = {verdict_q, cone_verdict()};
    end
    if (!rst && done) begin
      tests_seen++;
      if (result.removable) removable_seen++;
      if (result.degenerate) degenerate_seen++;
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %b", result);
      end else begin
        if (result.removable !== verdict_q[0].removable ||
            result.degenerate !== verdict_q[0].degenerate) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected removable=%b degenerate=%b, got removable=%b degenerate=%b",
                     verdict_q[0].removable, verdict_q[0].degenerate,
                     result.removable, result.degenerate);
        end
        void'(verdict_q.pop_front());
      end
    end
    if (!rst && !(start && !busy) && !done) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tetra_inscribed_cone_test_core test failed");
      $finish;
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst && (!start || beat_taken)) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (vertex_q.size() > 0) begin
        item <= vertex_q.pop_front();
        start <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 14);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic logic signed [31:0] rand_coord(input int scale);
    case (scale)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return $signed($urandom_range(0, 16)) * 32'sh0001_0000 - 32'sh0008_0000;
    endcase
  endfunction

  task automatic add_vertex(input logic [2:0] s, input logic signed [31:0] x,
                            input logic signed [31:0] y, input logic signed [31:0] z);
    item_t v;
    v.vertex_slot = s;
    v.coord_x = x;
    v.coord_y = y;
    v.coord_z = z;
    vertex_q = {vertex_q, v};
  endtask

  task automatic add_tetra(output int n);
    int scale;
    int kind;
    logic signed [31:0] px, py, pz;
    scale = $urandom_range(0, 2);
    kind = $urandom_range(0, 19);
    n = 0;
    px = rand_coord(scale);
    py = rand_coord(scale);
    pz = rand_coord(scale);
    for (int s = 0; s < 6; s++) begin
      if (s == 3 && kind == 1) continue;
      if (kind == 0) add_vertex(s[2:0], px, py, pz);
      else if (kind == 2 && s >= 4) add_vertex(s[2:0], rand_coord(scale), py, rand_coord(scale));
      else if (kind == 3 && s == 0) add_vertex(3'd0, px, py, pz);
      else if (kind == 3 && s == 3) add_vertex(3'd3, px, py, pz);
      else add_vertex(s[2:0], rand_coord(scale), rand_coord(scale), rand_coord(scale));
      n++;
    end
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == REG_SINE_LIMIT) sine_limit = data[15:0];
  endtask

  task automatic drain();
    wait (vertex_q.size() == 0 && !start && verdict_q.size() == 0 && !busy);
    repeat (16) @(negedge clk);
  endtask

  initial begin
    int n;
    int fed;
    logic [31:0] limits[5];
    limits[0] = 32'd11943;
    limits[1] = 32'd0;
    limits[2] = 32'd65535;
    limits[3] = $urandom_range(1, 65534);
    limits[4] = {16'd0, SINE_RESET};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // right-angled corner tetra, apex picked from three candidates
    add_vertex(3'd0, 0, 0, 0);
    add_vertex(3'd1, 32'sh0001_0000, 0, 0);
    add_vertex(3'd2, 0, 0, 32'sh0001_0000);
    add_vertex(3'd3, 0, 32'sh0001_0000, 0);
    add_vertex(3'd4, 32'sh0000_4000, 32'sh0001_0000, 0);
    add_vertex(3'd5, 32'sh0000_4000, -32'sh0001_0000, 32'sh0000_4000);
    // apex sitting on a base vertex: flat body
    add_vertex(3'd3, 0, 0, 0);
    add_vertex(3'd4, 5, -1, 5);
    add_vertex(3'd5, 7, -5, 7);
    // apex compared against stored one without a fresh slot 3
    add_vertex(3'd4, 32'sh0002_0000, 32'sh0003_0000, 32'sh0001_0000);
    add_vertex(3'd5, 0, 32'sh0003_0000, 0);
    // extremes of the coordinates, unused slots ignored
    add_vertex(3'd6, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    add_vertex(3'd7, 32'h8000_0000, 32'h7fff_ffff, 0);
    add_vertex(3'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_vertex(3'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_vertex(3'd2, 32'h8000_0000, 32'h7fff_ffff, 0);
    add_vertex(3'd3, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    add_vertex(3'd5, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    // everything on one point: degenerate
    for (int s = 0; s < 6; s++) add_vertex(s[2:0], 32'sh0001_0000, 0, -32'sh0001_0000);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      reg_write(REG_SINE_LIMIT, limits[ph]);
      reg_write(REG_UNUSED, $urandom);
      fed = 0;
      while (fed < 285) begin
        if ($urandom_range(0, 9) < 8) begin
          add_tetra(n);
          fed += n;
        end else begin
          add_vertex(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
          fed++;
        end
      end
      drain();
    end

    repeat (200) @(negedge clk);
    $display("covered %0d cone tests over 5 limit settings: %0d removable, %0d degenerate",
             tests_seen, removable_seen, degenerate_seen);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("tetra_inscribed_cone_test_core test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, verdict_q.size());
      $display("tetra_inscribed_cone_test_core test failed");
    end
    $finish;
  end

endmodule
